// ===== hdl/prt_pkg.sv =====
// prt_pkg: shared types and codes for the prefix route table
// holds transaction payload structs, route entry record, cell control struct and controller states
// no dependencies
package prt_pkg;

  // request modes
  typedef enum logic [1:0] {
    MODE_LOOKUP   = 2'd0,
    MODE_ADD      = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_REM_PORT = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // action applied alike by every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_MARK   = 2'd1,
    CELL_WALK   = 2'd2,
    CELL_INSERT = 2'd3
  } cell_op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_MARK, ST_WALK, ST_INSERT, ST_RESP
  } state_e;

  localparam int unsigned FlagBcastBit = 0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] dest_addr;
    logic [31:0] prefix_mask;
    logic [31:0] gateway_addr;
    logic [1:0]  port_id;
    logic        any_port;
    logic [3:0]  route_flags;
    logic [15:0] route_metric;
    logic        delete_broadcast;
  } in_data_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] hit_gateway;
    logic [1:0]  hit_port;
    logic [3:0]  hit_flags;
  } out_data_t;

  // one stored route
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
    logic [3:0]  flags;
    logic [15:0] metric;
  } entry_t;

  // lookup token travelling along the row
  typedef struct packed {
    logic        found;
    logic [31:0] gateway;
    logic [1:0]  port;
    logic [3:0]  flags;
  } carry_t;

  typedef struct packed {
    cell_op_e op;
    in_data_t req;
  } cell_ctrl_t;

endpackage

// ===== hdl/prt_cell.sv =====
// prt_cell: one slot of the route table row
// holds one entry, compacts towards lower slots, inserts in sorted order, passes lookup token
// depends on prt_pkg
module prt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prt_pkg::cell_ctrl_t ctrl_i,
  input  prt_pkg::entry_t     left_entry_i,
  input  logic                left_valid_i,
  input  logic                left_ins_i,
  input  prt_pkg::entry_t     right_entry_i,
  input  logic                right_valid_i,
  input  prt_pkg::carry_t     carry_i,
  output prt_pkg::entry_t     entry_o,
  output logic                valid_o,
  output logic                ins_o,
  output prt_pkg::carry_t     carry_o
);

  prt_pkg::entry_t entry_q, entry_d, new_entry;
  prt_pkg::carry_t carry_q, carry_d, own_carry;
  logic            valid_q, valid_d;
  logic            del_hit, lk_hit, goes_before, port_sel;
  prt_pkg::in_data_t req;

  assign req = ctrl_i.req;

  // route built from the request
  always_comb begin
    new_entry.dest    = req.dest_addr & req.prefix_mask;
    new_entry.mask    = req.prefix_mask;
    new_entry.gateway = req.gateway_addr;
    new_entry.port    = req.port_id;
    new_entry.flags   = req.route_flags;
    new_entry.metric  = req.route_metric;
  end

  assign port_sel = req.any_port || (entry_q.port == req.port_id);

  // entry selected for deletion by the current request
  always_comb begin
    case (prt_pkg::mode_e'(req.mode))
      prt_pkg::MODE_ADD: begin
        del_hit = (entry_q.dest == new_entry.dest) && (entry_q.mask == req.prefix_mask) &&
                  ((req.prefix_mask != 32'd0) || (entry_q.gateway == req.gateway_addr));
      end
      prt_pkg::MODE_REMOVE: begin
        del_hit = (entry_q.dest == req.dest_addr) && (entry_q.mask == req.prefix_mask) &&
                  (entry_q.gateway == req.gateway_addr);
      end
      prt_pkg::MODE_REM_PORT: begin
        del_hit = port_sel &&
                  (req.delete_broadcast || !entry_q.flags[prt_pkg::FlagBcastBit]);
      end
      default: del_hit = 1'b0;
    endcase
  end

  // lookup match and sort position
  assign lk_hit = valid_q && (prt_pkg::mode_e'(req.mode) == prt_pkg::MODE_LOOKUP) &&
                  ((req.dest_addr & entry_q.mask) == entry_q.dest) && port_sel;
  assign goes_before = (req.prefix_mask > entry_q.mask) ||
                       ((req.prefix_mask == entry_q.mask) &&
                        (req.route_metric < entry_q.metric));
  assign ins_o = !valid_q || goes_before;

  always_comb begin
    own_carry.found   = 1'b1;
    own_carry.gateway = entry_q.gateway;
    own_carry.port    = entry_q.port;
    own_carry.flags   = entry_q.flags;
  end

  // next slot contents
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    carry_d = carry_q;
    case (ctrl_i.op)
      prt_pkg::CELL_MARK: begin
        if (valid_q && del_hit) begin
          valid_d = 1'b0;
        end
        carry_d = '0;
      end
      prt_pkg::CELL_WALK: begin
        // empty slot pulls from the right, a slot with a hole below gives away
        if (!valid_q) begin
          entry_d = right_entry_i;
          valid_d = right_valid_i;
        end else if (!left_valid_i) begin
          valid_d = 1'b0;
        end
        if (carry_i.found) begin
          carry_d = carry_i;
        end else if (lk_hit) begin
          carry_d = own_carry;
        end else begin
          carry_d = '0;
        end
      end
      prt_pkg::CELL_INSERT: begin
        if (ins_o) begin
          if (left_ins_i) begin
            entry_d = left_entry_i;
            valid_d = left_valid_i;
          end else begin
            entry_d = new_entry;
            valid_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // route payload and token
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    carry_q <= carry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign carry_o = carry_q;

endmodule

// ===== hdl/prefix_route_table.sv =====
// Prefix route table: a sorted IPv4 route table with longest prefix match.
// Request channel in_valid_i/in_ready_o/in_data_i carries one transaction per
// lookup, add, exact remove or remove by interface. Response channel
// out_valid_o/out_ready_i/out_data_o returns one transaction for each request.
// Entries live in a row of TABLE_ENTRIES cells, kept packed and sorted
// by mask (longer first) then metric (lower first).
// Steps: a mark state, a walk state across the whole row in which a lookup
// token travels one cell per cycle and holes compact one slot per cycle, an
// insert state for add only, and a response state. A rejected add goes from
// the mark state straight to the response state.
// One request is worked on at a time; the walk length sets the rate.
// The next request is taken while a finished response still waits.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the response is held and the block waits after
// finishing the following request until the output register is free.
// depends on prt_pkg and prt_cell
module prefix_route_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned PORT_COUNT    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  prt_pkg::in_data_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output prt_pkg::out_data_t out_data_o
);

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES);

  prt_pkg::state_e      state_q, state_d;
  prt_pkg::in_data_t    req_q;
  logic [CntW-1:0]      cnt_q;
  logic [1:0]           status_q;
  logic                 out_valid_q;
  prt_pkg::out_data_t   out_q, resp;
  prt_pkg::cell_ctrl_t  ctrl;
  logic                 add_reject, table_full, walk_done, out_free;
  logic [31:0]          mask_inv;

  prt_pkg::entry_t      entry [TABLE_ENTRIES];
  logic                 valid [TABLE_ENTRIES];
  logic                 ins   [TABLE_ENTRIES];
  prt_pkg::carry_t      carry [TABLE_ENTRIES];

  // add parameter check
  assign mask_inv   = ~req_q.prefix_mask;
  assign add_reject = (prt_pkg::mode_e'(req_q.mode) == prt_pkg::MODE_ADD) &&
                      (((mask_inv & (mask_inv + 32'd1)) != 32'd0) ||
                       (req_q.gateway_addr == 32'd0) ||
                       ((req_q.gateway_addr == '1) &&
                        !req_q.route_flags[prt_pkg::FlagBcastBit]) ||
                       (32'(req_q.port_id) >= PORT_COUNT));
  assign table_full = valid[TABLE_ENTRIES-1];
  assign walk_done  = (cnt_q == CntW'(TABLE_ENTRIES - 1));
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      prt_pkg::ST_IDLE:   if (in_valid_i) state_d = prt_pkg::ST_MARK;
      prt_pkg::ST_MARK:   state_d = add_reject ? prt_pkg::ST_RESP : prt_pkg::ST_WALK;
      prt_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = (prt_pkg::mode_e'(req_q.mode) == prt_pkg::MODE_ADD) ?
                    prt_pkg::ST_INSERT : prt_pkg::ST_RESP;
        end
      end
      prt_pkg::ST_INSERT: state_d = prt_pkg::ST_RESP;
      prt_pkg::ST_RESP:   if (out_free) state_d = prt_pkg::ST_IDLE;
      default:            state_d = prt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctrl.op    = prt_pkg::CELL_HOLD;
    ctrl.req   = req_q;
    case (state_q)
      prt_pkg::ST_IDLE:   in_ready_o = 1'b1;
      prt_pkg::ST_MARK:   if (!add_reject) ctrl.op = prt_pkg::CELL_MARK;
      prt_pkg::ST_WALK:   ctrl.op = prt_pkg::CELL_WALK;
      prt_pkg::ST_INSERT: if (!table_full) ctrl.op = prt_pkg::CELL_INSERT;
      default: ;
    endcase
  end

  // cell row
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    prt_pkg::entry_t l_entry, r_entry;
    logic            l_valid, l_ins, r_valid;
    prt_pkg::carry_t c_in;
    if (i == 0) begin : g_first
      assign l_entry = '0;
      assign l_valid = 1'b1;
      assign l_ins   = 1'b0;
      assign c_in    = '0;
    end else begin : g_mid
      assign l_entry = entry[i-1];
      assign l_valid = valid[i-1];
      assign l_ins   = ins[i-1];
      assign c_in    = carry[i-1];
    end
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry[i+1];
      assign r_valid = valid[i+1];
    end
    prt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_entry_i  (l_entry),
      .left_valid_i  (l_valid),
      .left_ins_i    (l_ins),
      .right_entry_i (r_entry),
      .right_valid_i (r_valid),
      .carry_i       (c_in),
      .entry_o       (entry[i]),
      .valid_o       (valid[i]),
      .ins_o         (ins[i]),
      .carry_o       (carry[i])
    );
  end

  // response built from status and lookup token
  always_comb begin
    resp        = '0;
    resp.status = status_q;
    if ((prt_pkg::mode_e'(req_q.mode) == prt_pkg::MODE_LOOKUP) &&
        (req_q.dest_addr != 32'd0) && carry[TABLE_ENTRIES-1].found) begin
      resp.hit         = 1'b1;
      resp.hit_gateway = carry[TABLE_ENTRIES-1].gateway;
      resp.hit_port    = carry[TABLE_ENTRIES-1].port;
      resp.hit_flags   = carry[TABLE_ENTRIES-1].flags;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      status_q    <= prt_pkg::STATUS_OK;
    end else begin
      state_q <= state_d;
      if (state_q == prt_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == prt_pkg::ST_WALK) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (in_valid_i && in_ready_o) begin
        status_q <= prt_pkg::STATUS_OK;
      end else if (state_q == prt_pkg::ST_MARK && add_reject) begin
        status_q <= prt_pkg::STATUS_INVALID;
      end else if (state_q == prt_pkg::ST_INSERT && table_full) begin
        status_q <= prt_pkg::STATUS_FULL;
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (state_q == prt_pkg::ST_RESP && out_free) begin
      out_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/prt_checker.sv =====
// prt_checker: port level checks for the prefix route table
// bound to prefix_route_table; depends on prt_pkg
module prt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input prt_pkg::in_data_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input prt_pkg::out_data_t out_data_o
);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // status code range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("unknown status code");

  // a hit only with ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.status == prt_pkg::STATUS_OK)
    else $error("hit with error status");

  // miss fields are zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.hit_gateway == 32'd0 &&
      out_data_o.hit_port == 2'd0 && out_data_o.hit_flags == 4'd0)
    else $error("miss carries route fields");

endmodule

bind prefix_route_table prt_checker u_prt_checker (.*);

// ===== dv/tb_prefix_route_table.sv =====
// tb_prefix_route_table: self-checking bench for the prefix route table
// drives lookup, add and remove transactions, checks responses against a local table model
// depends on prt_pkg and prefix_route_table
`timescale 1ns / 1ps

module tb_prefix_route_table;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned NumPorts   = 4;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned DrainWait  = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  prt_pkg::in_data_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  prt_pkg::out_data_t out_data_o;

  prefix_route_table #(
    .TABLE_ENTRIES(NumEntries),
    .PORT_COUNT   (NumPorts)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the route table
  prt_pkg::entry_t    rt_entry[NumEntries];
  int unsigned        rt_used;

  prt_pkg::out_data_t pending_resp[$];
  int unsigned        fail_count;
  int unsigned        idle_cycles;
  bit                 hold_long;

  // stimulus table row: transaction plus optional fixed response
  typedef struct {
    prt_pkg::in_data_t  req;
    bit                 fixed;
    prt_pkg::out_data_t resp;
  } dir_row_t;

  function automatic bit mask_contig(logic [31:0] m);
    logic [31:0] inv;
    inv = ~m;
    return (inv & (inv + 32'd1)) == 32'd0;
  endfunction

  function automatic void drop_route(int unsigned k);
    for (int unsigned i = k; i + 1 < rt_used; i++) rt_entry[i] = rt_entry[i + 1];
    rt_used--;
  endfunction

  // route table behaviour for one transaction
  function automatic prt_pkg::out_data_t route_predict(prt_pkg::in_data_t r);
    prt_pkg::out_data_t o;
    prt_pkg::entry_t    e;
    int unsigned        i;
    int unsigned        pos;
    logic [31:0]        d;
    bit                 found;
    bit                 sel;
    o = '0;
    case (prt_pkg::mode_e'(r.mode))
      prt_pkg::MODE_LOOKUP: begin
        if (r.dest_addr != 32'd0) begin
          for (i = 0; i < rt_used; i++) begin
            if ((r.dest_addr & rt_entry[i].mask) == rt_entry[i].dest &&
                (r.any_port || rt_entry[i].port == r.port_id)) begin
              o.hit         = 1'b1;
              o.hit_gateway = rt_entry[i].gateway;
              o.hit_port    = rt_entry[i].port;
              o.hit_flags   = rt_entry[i].flags;
              break;
            end
          end
        end
      end
      prt_pkg::MODE_ADD: begin
        if (!mask_contig(r.prefix_mask) || r.gateway_addr == 32'd0 ||
            (r.gateway_addr == '1 && !r.route_flags[prt_pkg::FlagBcastBit]) ||
            r.port_id >= NumPorts) begin
          o.status = prt_pkg::STATUS_INVALID;
        end else begin
          d = r.dest_addr & r.prefix_mask;
          found = 1'b0;
          for (i = 0; i < rt_used; i++) begin
            if (rt_entry[i].dest == d && rt_entry[i].mask == r.prefix_mask &&
                (r.prefix_mask != 0 || rt_entry[i].gateway == r.gateway_addr)) begin
              found = 1'b1;
              break;
            end
          end
          if (found) drop_route(i);
          if (!found && rt_used >= NumEntries) begin
            o.status = prt_pkg::STATUS_FULL;
          end else begin
            for (pos = 0; pos < rt_used; pos++) begin
              if (r.prefix_mask > rt_entry[pos].mask ||
                  (r.prefix_mask == rt_entry[pos].mask &&
                   r.route_metric < rt_entry[pos].metric)) break;
            end
            for (i = rt_used; i > pos; i--) rt_entry[i] = rt_entry[i - 1];
            e.dest = d;  e.mask = r.prefix_mask;  e.gateway = r.gateway_addr;
            e.port = r.port_id;  e.flags = r.route_flags;  e.metric = r.route_metric;
            rt_entry[pos] = e;
            rt_used++;
          end
        end
      end
      prt_pkg::MODE_REMOVE: begin
        for (i = 0; i < rt_used; i++) begin
          if (rt_entry[i].dest == r.dest_addr && rt_entry[i].mask == r.prefix_mask &&
              rt_entry[i].gateway == r.gateway_addr) begin
            drop_route(i);
            break;
          end
        end
      end
      default: begin
        i = 0;
        while (i < rt_used) begin
          sel = (r.any_port || rt_entry[i].port == r.port_id) &&
                (r.delete_broadcast || !rt_entry[i].flags[prt_pkg::FlagBcastBit]);
          if (sel) drop_route(i);
          else i++;
        end
      end
    endcase
    return o;
  endfunction

  function automatic prt_pkg::in_data_t make_req(prt_pkg::mode_e m, logic [31:0] d,
                                                 logic [31:0] msk, logic [31:0] gw,
                                                 logic [1:0] p, logic anyp,
                                                 logic [3:0] fl, logic [15:0] met,
                                                 logic delb);
    prt_pkg::in_data_t r;
    r.mode = m;  r.dest_addr = d;  r.prefix_mask = msk;  r.gateway_addr = gw;
    r.port_id = p;  r.any_port = anyp;  r.route_flags = fl;
    r.route_metric = met;  r.delete_broadcast = delb;
    return r;
  endfunction

  function automatic logic [31:0] prefix_of(int unsigned len);
    return (len == 0) ? 32'd0 : ~(32'hFFFF_FFFF >> len);
  endfunction

  // random transaction, mostly well formed, with a reused pool of prefixes
  function automatic prt_pkg::in_data_t rand_req();
    prt_pkg::in_data_t r;
    int unsigned       pick;
    int unsigned       len;
    r.mode             = prt_pkg::MODE_LOOKUP;
    r.dest_addr        = $urandom;
    r.prefix_mask      = $urandom;
    r.gateway_addr     = $urandom;
    r.port_id          = 2'($urandom);
    r.any_port         = 1'($urandom);
    r.route_flags      = 4'($urandom);
    r.route_metric     = 16'($urandom);
    r.delete_broadcast = 1'($urandom);
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : 8 * $urandom_range(0, 4);
    if ($urandom_range(0, 9) != 0) begin
      r.dest_addr = {8'd10, 6'd0, 2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)};
      r.prefix_mask = prefix_of(len);
      if ($urandom_range(0, 4) != 0) r.gateway_addr = {24'hC0A800, 6'd0, 2'($urandom)};
      if ($urandom_range(0, 3) != 0) r.route_metric = 16'($urandom_range(0, 3));
    end
    if (pick < 40)      r.mode = prt_pkg::MODE_LOOKUP;
    else if (pick < 80) r.mode = prt_pkg::MODE_ADD;
    else if (pick < 95) begin
      r.mode = prt_pkg::MODE_REMOVE;
      r.dest_addr = r.dest_addr & r.prefix_mask;
    end else            r.mode = prt_pkg::MODE_REM_PORT;
    return r;
  endfunction

  // response checker and watchdog
  always @(posedge clk_i) begin
    prt_pkg::out_data_t exp_resp;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_resp.size() == 0) begin
          $display("%0t: unexpected response %h", $time, out_data_o);
          fail_count++;
        end else begin
          exp_resp = pending_resp.pop_front();
          if (out_data_o.status !== exp_resp.status ||
              out_data_o.hit !== exp_resp.hit ||
              out_data_o.hit_gateway !== exp_resp.hit_gateway ||
              out_data_o.hit_port !== exp_resp.hit_port ||
              out_data_o.hit_flags !== exp_resp.hit_flags) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_resp, out_data_o);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: stall pattern with a single long hold-off
  initial begin
    int unsigned phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_long = 1'b0;
      end
      phase++;
      if ((phase / 200) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end
  end

  task automatic send_req(prt_pkg::in_data_t r, bit fixed, prt_pkg::out_data_t resp);
    prt_pkg::out_data_t model_resp;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_resp = route_predict(r);
    if (fixed && model_resp != resp)
      $display("%0t: table row disagrees with predictor for %h", $time, r);
    pending_resp.push_back(fixed ? resp : model_resp);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_resp.size() != 0) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    dir_row_t           dir_tab[$];
    dir_row_t           row;
    prt_pkg::out_data_t none;
    prt_pkg::out_data_t inv;
    int unsigned        burst;
    bit                 held;
    bit                 drained;
    fail_count  = 0;
    idle_cycles = 0;
    hold_long   = 1'b0;
    held        = 1'b0;
    drained     = 1'b0;
    rt_used     = 0;
    none = '0;
    inv = '0;
    inv.status = prt_pkg::STATUS_INVALID;

    dir_tab.push_back('{make_req(prt_pkg::MODE_LOOKUP, 32'h0A000001, 0, 0, 0, 1, 0, 0, 0),
                        1, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_LOOKUP, 32'hFFFFFFFF, 0, 0, 3, 0, 0, 0, 0),
                        1, none});
    // bad mask, zero gateway, all-ones gateway without broadcast
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0A000000, 32'hFF00FF00, 32'h1, 0, 0,
                                 0, 0, 0), 1, inv});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0A000000, 32'hFF000000, 32'h0, 0, 0,
                                 0, 0, 0), 1, inv});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0A000000, 32'hFF000000, '1, 1, 0,
                                 4'hE, 0, 0), 1, inv});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'hFFFFFFFF, '1, '1, 3, 0, 4'hF,
                                 16'hFFFF, 1), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0A0B0C0D, 32'hFF000000, 32'hC0A80001,
                                 1, 0, 4'h2, 16'd5, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h12345678, 32'h0, 32'hC0A80002, 2, 0,
                                 4'h1, 0, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0, 32'h0, 32'hC0A80003, 0, 0, 4'h8,
                                 16'd9, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0A000000, 32'hFF000000, 32'hC0A80004,
                                 0, 0, 4'h4, 16'd5, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_ADD, 32'h0A000000, 32'hFF000000, 32'hC0A80005,
                                 1, 0, 0, 16'd1, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_LOOKUP, 32'h0A010101, 0, 0, 0, 1, 0, 0, 0),
                        0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_LOOKUP, 32'h0A010101, 0, 0, 2, 0, 0, 0, 0),
                        0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 1, 0, 0, 0),
                        0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_REMOVE, 32'h0A0B0C0D, 32'hFF000000,
                                 32'hC0A80005, 0, 0, 0, 0, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_REMOVE, 32'h0A000000, 32'hFF000000,
                                 32'hC0A80005, 0, 0, 0, 0, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_REM_PORT, 0, 0, 0, 2, 0, 0, 0, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_REM_PORT, 0, 0, 0, 0, 1, 0, 0, 0), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_REM_PORT, 0, 0, 0, 1, 0, 0, 0, 1), 0, none});
    dir_tab.push_back('{make_req(prt_pkg::MODE_LOOKUP, 32'h0A000001, 0, 0, 0, 1, 0, 0, 0),
                        0, none});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[k]) send_req(dir_tab[k].req, dir_tab[k].fixed, dir_tab[k].resp);

    // add one route more than the table has slots, so the last adds hit the full case
    for (int unsigned k = 0; k <= NumEntries; k++)
      send_req(make_req(prt_pkg::MODE_ADD, 32'h20000000 + (k << 8), 32'hFFFFFF00, 32'h1 + k,
                        2'(k), 0, 0, 16'(k), 0), 0, none);
    send_req(make_req(prt_pkg::MODE_REM_PORT, 0, 0, 0, 0, 1, 0, 0, 1), 0, none);

    // random bursts; long receiver hold-off once, drained pause once
    for (int unsigned n = 0; n < 550; ) begin
      if (n >= 100 && !held) begin
        hold_long = 1'b1;
        held = 1'b1;
      end
      if (n >= 300 && !drained) begin
        in_valid_i <= 1'b0;
        wait_drained();
        drained = 1'b1;
      end
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst; b++) begin
        row.req = rand_req();
        send_req(row.req, 0, none);
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/prt_pkg.sv
hdl/prt_cell.sv
hdl/prefix_route_table.sv
hdl/prt_checker.sv
dv/tb_prefix_route_table.sv
